FILE: src/iocl_pkg.sv
package iocl_pkg;

    localparam int SEQ_W = 48;
    localparam int OFF_W = 48;
    localparam int POS_W = 47;

    localparam logic [1:0] KIND_APPEND   = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ACK      = 2'd2;

    localparam logic [2:0] ST_ACCEPTED      = 3'd0;
    localparam logic [2:0] ST_BACKPRESSURED = 3'd1;
    localparam logic [2:0] ST_DUPLICATE     = 3'd2;
    localparam logic [2:0] ST_SEQ_ORDER     = 3'd3;
    localparam logic [2:0] ST_OFF_ORDER     = 3'd4;
    localparam logic [2:0] ST_UNKNOWN       = 3'd5;
    localparam logic [2:0] ST_COMMIT_REJ    = 3'd6;

    localparam logic [SEQ_W-1:0] SEQ_ALL_ONES = {SEQ_W{1'b1}};
    localparam logic [OFF_W-1:0] OFF_MAX      = {1'b0, {(OFF_W-1){1'b1}}};

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic retire_step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic complete_ok;
        logic retire_avail;
    } sts_t;

endpackage

FILE: src/iocl_ctrl.sv
module iocl_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output iocl_pkg::cmd_t cmd,
    input  iocl_pkg::sts_t sts
);
    import iocl_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RETIRE, S_FINISH} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // commands decoded from state
    always_comb
    begin
        cmd.load_item   = (state_reg == S_IDLE) && in_valid;
        cmd.exec        = (state_reg == S_EXEC);
        cmd.retire_step = (state_reg == S_RETIRE);
        cmd.load_out    = (state_reg == S_FINISH) && out_free;
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = sts.complete_ok ? S_RETIRE : S_FINISH;
            end
            S_RETIRE:
            begin
                if (!sts.retire_avail)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> state_reg == S_EXEC)
        else $error("accepted beat did not enter execute");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result load lost");

    a_stalled_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("stalled result beat dropped");

endmodule

FILE: src/iocl_datapath.sv
module iocl_datapath #(
    parameter int DEPTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  iocl_pkg::cmd_t                    cmd,
    output iocl_pkg::sts_t                    sts,
    input  logic [1:0]                        kind,
    input  logic [iocl_pkg::SEQ_W-1:0]        sequence_req,
    input  logic signed [iocl_pkg::OFF_W-1:0] offset,
    output logic [2:0]                        status,
    output logic [4:0]                        pending,
    output logic                              contiguous_valid,
    output logic [iocl_pkg::SEQ_W-1:0]        contiguous_sequence,
    output logic [iocl_pkg::POS_W-1:0]        contiguous_offset,
    output logic                              commit_ready,
    output logic [iocl_pkg::POS_W-1:0]        commit_offset
);
    import iocl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int HW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW:0] DEPTH_C = (CW + 1)'(DEPTH);

    // latched item
    logic [1:0]              kind_reg;
    logic [SEQ_W-1:0]        seq_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic [2:0]              st_reg;

    // ledger state
    logic [DEPTH-1:0]        done_reg;
    logic [HW-1:0]           head_reg;
    logic [CW-1:0]           held_reg;
    logic [SEQ_W-1:0]        exp_seq_reg;
    logic                    exp_off_valid_reg;
    logic [POS_W-1:0]        exp_off_reg;
    logic                    dp_valid_reg;
    logic [SEQ_W-1:0]        dp_seq_reg;
    logic [POS_W-1:0]        dp_off_reg;
    logic                    cm_valid_reg;
    logic [POS_W-1:0]        cm_off_reg;

    // held entries carry consecutive sequences and offsets ending just below expected
    logic [SEQ_W-1:0]        base_seq;
    logic [POS_W-1:0]        head_off;
    logic                    found;
    logic [CW-1:0]           pos;
    logic [CW:0]             idx_sum;
    logic [HW-1:0]           idx;
    logic [HW-1:0]           head_inc;
    logic [POS_W-1:0]        commit_next;
    logic                    avail;
    logic                    full;

    assign base_seq = exp_seq_reg - SEQ_W'(held_reg);
    assign head_off = exp_off_reg - POS_W'(held_reg);
    assign found    = (seq_reg >= base_seq) && (seq_reg < exp_seq_reg);
    assign pos      = CW'(seq_reg - base_seq);
    assign idx_sum  = (CW + 1)'(head_reg) + (CW + 1)'(pos);
    assign idx      = (idx_sum >= DEPTH_C) ? HW'(idx_sum - DEPTH_C) : HW'(idx_sum);
    assign head_inc = ((CW + 1)'(head_reg) == DEPTH_C - 1'b1) ? '0 : head_reg + 1'b1;
    assign full     = ((CW + 1)'(held_reg) >= DEPTH_C);

    assign commit_next = dp_off_reg + 1'b1;
    assign avail       = dp_valid_reg && !(cm_valid_reg && (commit_next <= cm_off_reg));

    assign sts.complete_ok  = (kind_reg == KIND_COMPLETE) && found && !done_reg[idx];
    assign sts.retire_avail = (held_reg != '0) && done_reg[head_reg];

    // item latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= kind;
            seq_reg  <= sequence_req;
            off_reg  <= offset;
        end
    end

    // execute, retire and result load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg              <= ST_ACCEPTED;
            done_reg            <= '0;
            head_reg            <= '0;
            held_reg            <= '0;
            exp_seq_reg         <= '0;
            exp_off_valid_reg   <= 1'b0;
            exp_off_reg         <= '0;
            dp_valid_reg        <= 1'b0;
            dp_seq_reg          <= '0;
            dp_off_reg          <= '0;
            cm_valid_reg        <= 1'b0;
            cm_off_reg          <= '0;
            status              <= ST_ACCEPTED;
            pending             <= '0;
            contiguous_valid    <= 1'b0;
            contiguous_sequence <= '0;
            contiguous_offset   <= '0;
            commit_ready        <= 1'b0;
            commit_offset       <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                unique case (kind_reg)
                    KIND_APPEND:
                    begin
                        priority if (full)
                            st_reg <= ST_BACKPRESSURED;
                        else if (seq_reg < exp_seq_reg)
                            st_reg <= ST_DUPLICATE;
                        else if (seq_reg > exp_seq_reg)
                            st_reg <= ST_SEQ_ORDER;
                        else if (off_reg[OFF_W-1] ||
                                 (exp_off_valid_reg && off_reg[POS_W-1:0] != exp_off_reg))
                            st_reg <= ST_OFF_ORDER;
                        else if (seq_reg == SEQ_ALL_ONES || off_reg == OFF_MAX)
                            st_reg <= ST_SEQ_ORDER;
                        else
                        begin
                            st_reg            <= ST_ACCEPTED;
                            held_reg          <= held_reg + 1'b1;
                            exp_seq_reg       <= exp_seq_reg + 1'b1;
                            exp_off_reg       <= off_reg[POS_W-1:0] + 1'b1;
                            exp_off_valid_reg <= 1'b1;
                        end
                    end
                    KIND_COMPLETE:
                    begin
                        priority if (!found)
                            st_reg <= (dp_valid_reg && seq_reg <= dp_seq_reg)
                                      ? ST_DUPLICATE : ST_UNKNOWN;
                        else if (done_reg[idx])
                            st_reg <= ST_DUPLICATE;
                        else
                        begin
                            st_reg        <= ST_ACCEPTED;
                            done_reg[idx] <= 1'b1;
                        end
                    end
                    KIND_ACK:
                    begin
                        if (avail && !off_reg[OFF_W-1] && off_reg[POS_W-1:0] == commit_next)
                        begin
                            st_reg       <= ST_ACCEPTED;
                            cm_valid_reg <= 1'b1;
                            cm_off_reg   <= commit_next;
                        end
                        else
                            st_reg <= ST_COMMIT_REJ;
                    end
                    default:
                    begin
                        st_reg <= ST_UNKNOWN;
                    end
                endcase
            end

            // retire one done entry from the head
            if (cmd.retire_step && sts.retire_avail)
            begin
                dp_valid_reg       <= 1'b1;
                dp_seq_reg         <= base_seq;
                dp_off_reg         <= head_off;
                done_reg[head_reg] <= 1'b0;
                head_reg           <= head_inc;
                held_reg           <= held_reg - 1'b1;
            end

            if (cmd.load_out)
            begin
                status              <= st_reg;
                pending             <= 5'(held_reg);
                contiguous_valid    <= dp_valid_reg;
                contiguous_sequence <= dp_valid_reg ? dp_seq_reg : '0;
                contiguous_offset   <= dp_valid_reg ? dp_off_reg : '0;
                commit_ready        <= avail;
                commit_offset       <= avail ? commit_next : '0;
            end
        end
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 1)'(held_reg) <= DEPTH_C)
        else $error("held count above capacity");

    a_retire_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.retire_step && sts.retire_avail |=> held_reg == $past(held_reg) - 1'b1)
        else $error("retire did not drop held count");

    a_commit_needs_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        cm_valid_reg |-> dp_valid_reg)
        else $error("commit without completed prefix");

endmodule

FILE: src/in_order_completion_commit_ledger_unit.sv
// Channel | valid    | stall     | payload
// in      | in_valid | in_stall  | kind, sequence_req, offset
// out     | out_valid| out_stall | status, pending, contiguous_*, commit_*
//
// One beat in gives one beat out. An item passes through accept, execute and
// result load. An accepted complete adds a retire step before result load,
// retiring done head entries one by one (up to DEPTH) in a single-entry loop.
// in_stall is high from acceptance until the result is loaded in the output
// register; a new item is taken while that result still waits.
// rst_n clears the ledger asynchronously; no clearing pass is needed.
module in_order_completion_commit_ledger_unit #(
    parameter int DEPTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        kind,
    input  logic [iocl_pkg::SEQ_W-1:0]        sequence_req,
    input  logic signed [iocl_pkg::OFF_W-1:0] offset,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        status,
    output logic [4:0]                        pending,
    output logic                              contiguous_valid,
    output logic [iocl_pkg::SEQ_W-1:0]        contiguous_sequence,
    output logic [iocl_pkg::POS_W-1:0]        contiguous_offset,
    output logic                              commit_ready,
    output logic [iocl_pkg::POS_W-1:0]        commit_offset
);
    import iocl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    iocl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    iocl_datapath #(.DEPTH(DEPTH)) u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .kind                (kind),
        .sequence_req        (sequence_req),
        .offset              (offset),
        .status              (status),
        .pending             (pending),
        .contiguous_valid    (contiguous_valid),
        .contiguous_sequence (contiguous_sequence),
        .contiguous_offset   (contiguous_offset),
        .commit_ready        (commit_ready),
        .commit_offset       (commit_offset)
    );

endmodule
